[rtl/pci_resource_window_allocator_top_assert.svh]
// Assertion macros used by the checker file of this block.
`ifndef PCI_RESOURCE_WINDOW_ALLOCATOR_TOP_ASSERT_SVH
`define PCI_RESOURCE_WINDOW_ALLOCATOR_TOP_ASSERT_SVH

// Overlapping implication, checked while reset is released.
`define PRWA_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("prwa assertion failed");

// Implication whose consequent starts in the cycle after the antecedent.
`define PRWA_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("prwa assertion failed");

`endif

[rtl/prwa_pkg.sv]
`timescale 1ns / 1ps

package prwa_pkg;

  localparam int MAX_NESTING = 8;
  localparam int HOST_COUNT  = 2;

  localparam int HOST_W = (HOST_COUNT > 1) ? $clog2(HOST_COUNT) : 1;
  localparam int LVL_W  = $clog2(MAX_NESTING + 1);
  localparam int STK_W  = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(MAX_NESTING);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREF_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IO_START   = 2'd2;

  localparam logic [31:0] MEM_POOL_RST  = 32'h8000_0000;
  localparam logic [31:0] PREF_POOL_RST = 32'hA000_0000;
  localparam logic [15:0] IO_POOL_RST   = 16'h1000;

  localparam logic [31:0] MEM_GRAN_M1 = 32'h000F_FFFF;
  localparam logic [31:0] IO_GRAN_M1  = 32'h0000_0FFF;

  localparam logic [31:0] ROM_AMASK = 32'hFFFF_F800;
  localparam logic [31:0] IO_AMASK  = 32'hFFFF_FFFC;
  localparam logic [31:0] MEM_AMASK = 32'hFFFF_FFF0;

  localparam logic [15:0] MEM_WIN_OFF = 16'hFFF0;
  localparam logic [7:0]  IO_WIN_OFF  = 8'hF0;

  localparam logic [2:0] CMD_IO     = 3'b001;
  localparam logic [2:0] CMD_MEM    = 3'b010;
  localparam logic [2:0] CMD_MASTER = 3'b100;

  localparam logic [7:0] BUS_FIRST = 8'd1;

  typedef enum logic [2:0] {
    OP_BAR   = 3'd0,
    OP_ROM   = 3'd1,
    OP_ENTER = 3'd2,
    OP_LEAVE = 3'd3,
    OP_START = 3'd4
  } opcode_t;

  typedef struct packed {
    logic capture;
    logic calc;
    logic commit;
  } ctl_t;

endpackage

[rtl/pci_resource_window_allocator_top.sv]
// Once an input beat is accepted and captured, its result beat appears after the calculate and commit steps.
// The block takes no new item until the last one is committed; capture, calculate and commit steps
// of the controller run in turn, and commit waits while the output is stalled.
// Reset: synchronous, active low; pool starts return to their default values,
// the bus counter to one and the nesting level to zero.
`timescale 1ns / 1ps

module pci_resource_window_allocator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [prwa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     in_opcode,
  input  logic                           in_host_select,
  input  logic [31:0]                    in_original_word,
  input  logic [31:0]                    in_readback_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [31:0]                    out_bar_word,
  output logic [31:0]                    out_region_size,
  output logic                           out_wide_bar,
  output logic [2:0]                     out_command_bits,
  output logic [7:0]                     out_bus_number,
  output logic [15:0]                    out_mem_window_base,
  output logic [15:0]                    out_mem_window_limit,
  output logic [15:0]                    out_pref_window_base,
  output logic [15:0]                    out_pref_window_limit,
  output logic [7:0]                     out_io_window_base,
  output logic [7:0]                     out_io_window_limit,
  output logic                           out_nesting_error
);
  import prwa_pkg::*;

  ctl_t ctl;

  prwa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  prwa_datapath u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .ctl                   (ctl),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_opcode             (in_opcode),
    .in_host_select        (in_host_select),
    .in_original_word      (in_original_word),
    .in_readback_word      (in_readback_word),
    .out_bar_word          (out_bar_word),
    .out_region_size       (out_region_size),
    .out_wide_bar          (out_wide_bar),
    .out_command_bits      (out_command_bits),
    .out_bus_number        (out_bus_number),
    .out_mem_window_base   (out_mem_window_base),
    .out_mem_window_limit  (out_mem_window_limit),
    .out_pref_window_base  (out_pref_window_base),
    .out_pref_window_limit (out_pref_window_limit),
    .out_io_window_base    (out_io_window_base),
    .out_io_window_limit   (out_io_window_limit),
    .out_nesting_error     (out_nesting_error)
  );

endmodule

[rtl/prwa_datapath.sv]
`timescale 1ns / 1ps

module prwa_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  prwa_pkg::ctl_t                 ctl,
  input  logic                           cfg_we,
  input  logic [prwa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata,
  input  logic [2:0]                     in_opcode,
  input  logic                           in_host_select,
  input  logic [31:0]                    in_original_word,
  input  logic [31:0]                    in_readback_word,
  output logic [31:0]                    out_bar_word,
  output logic [31:0]                    out_region_size,
  output logic                           out_wide_bar,
  output logic [2:0]                     out_command_bits,
  output logic [7:0]                     out_bus_number,
  output logic [15:0]                    out_mem_window_base,
  output logic [15:0]                    out_mem_window_limit,
  output logic [15:0]                    out_pref_window_base,
  output logic [15:0]                    out_pref_window_limit,
  output logic [7:0]                     out_io_window_base,
  output logic [7:0]                     out_io_window_limit,
  output logic                           out_nesting_error
);
  import prwa_pkg::*;

  typedef enum logic [1:0] {
    POOL_MEM,
    POOL_PREF,
    POOL_IO
  } pool_sel_t;

  logic [31:0] mem_start_r;
  logic [31:0] pref_start_r;
  logic [15:0] io_start_r;

  logic [31:0] mem_next_r  [HOST_COUNT];
  logic [31:0] pref_next_r [HOST_COUNT];
  logic [31:0] io_next_r   [HOST_COUNT];
  logic [7:0]       bus_r;
  logic [LVL_W-1:0] level_r;

  logic [31:0] stk_mem  [MAX_NESTING];
  logic [31:0] stk_pref [MAX_NESTING];
  logic [31:0] stk_io   [MAX_NESTING];

  logic [2:0]        op_r;
  logic [HOST_W-1:0] host_r;
  logic [31:0]       orig_r;
  logic [31:0]       rb_r;

  logic [31:0] base_r;
  logic [31:0] size_r;
  logic [31:0] flags_r;
  pool_sel_t   sel_r;
  logic        rom_r;
  logic        io_r;
  logic        impl_r;
  logic [31:0] t_r [3];

  logic [31:0] bar_word_r;
  logic [31:0] region_size_r;
  logic        wide_bar_r;
  logic [2:0]  command_bits_r;
  logic [7:0]  bus_number_r;
  logic [15:0] mem_base_r;
  logic [15:0] mem_limit_r;
  logic [15:0] pref_base_r;
  logic [15:0] pref_limit_r;
  logic [7:0]  io_base_r;
  logic [7:0]  io_limit_r;
  logic        nest_err_r;

  logic        is_rom;
  logic        is_io;
  logic [31:0] amask;
  logic [31:0] x;
  logic [31:0] flags;
  pool_sel_t   sel;
  logic [31:0] pool_cur;
  logic [31:0] mem_cur;
  logic [31:0] pref_cur;
  logic [31:0] io_cur;
  logic [LVL_W-1:0] lvl_m1;
  logic [STK_W-1:0] rd_idx;
  logic [STK_W-1:0] wr_idx;

  logic        lvl_full;
  logic        lvl_empty;
  logic        mem_en;
  logic        pref_en;
  logic        io_en;
  logic [31:0] mem_m1;
  logic [31:0] pref_m1;
  logic [31:0] io_m1;
  logic [31:0] mem_rnd;
  logic [31:0] pref_rnd;
  logic [31:0] io_rnd;
  logic [31:0] pool_adv;

  logic [31:0] bar_word_nxt;
  logic [31:0] region_size_nxt;
  logic        wide_bar_nxt;
  logic [2:0]  command_bits_nxt;
  logic [7:0]  bus_number_nxt;
  logic [15:0] mem_base_nxt;
  logic [15:0] mem_limit_nxt;
  logic [15:0] pref_base_nxt;
  logic [15:0] pref_limit_nxt;
  logic [7:0]  io_base_nxt;
  logic [7:0]  io_limit_nxt;
  logic        nest_err_nxt;

  assign mem_cur  = mem_next_r[host_r];
  assign pref_cur = pref_next_r[host_r];
  assign io_cur   = io_next_r[host_r];

  assign is_rom = (op_r == OP_ROM);
  assign is_io  = !is_rom && orig_r[0];
  assign amask  = is_rom ? ROM_AMASK : (is_io ? IO_AMASK : MEM_AMASK);
  assign x      = rb_r & amask;
  assign flags  = orig_r & ~amask;

  always_comb begin
    if (is_rom || (!is_io && !flags[3])) begin
      sel = POOL_MEM;
    end else if (is_io) begin
      sel = POOL_IO;
    end else begin
      sel = POOL_PREF;
    end
  end

  always_comb begin
    unique case (sel)
      POOL_MEM:  pool_cur = mem_cur;
      POOL_PREF: pool_cur = pref_cur;
      POOL_IO:   pool_cur = io_cur;
      default:   pool_cur = mem_cur;
    endcase
  end

  assign lvl_m1 = level_r - LVL_W'(1);
  assign rd_idx = lvl_m1[STK_W-1:0];
  assign wr_idx = level_r[STK_W-1:0];

  assign lvl_full  = (level_r >= LVL_MAX);
  assign lvl_empty = (level_r == '0);

  assign mem_en   = mem_cur > t_r[0];
  assign pref_en  = pref_cur > t_r[1];
  assign io_en    = io_cur > t_r[2];
  assign mem_m1   = mem_cur - 32'd1;
  assign pref_m1  = pref_cur - 32'd1;
  assign io_m1    = io_cur - 32'd1;
  assign mem_rnd  = (mem_cur + MEM_GRAN_M1) & ~MEM_GRAN_M1;
  assign pref_rnd = (pref_cur + MEM_GRAN_M1) & ~MEM_GRAN_M1;
  assign io_rnd   = (io_cur + IO_GRAN_M1) & ~IO_GRAN_M1;
  assign pool_adv = base_r + size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_start_r  <= MEM_POOL_RST;
      pref_start_r <= PREF_POOL_RST;
      io_start_r   <= IO_POOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MEM_START:  mem_start_r  <= cfg_wdata;
        CFG_PREF_START: pref_start_r <= cfg_wdata;
        CFG_IO_START:   io_start_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int h = 0; h < HOST_COUNT; h++) begin
        mem_next_r[h]  <= MEM_POOL_RST;
        pref_next_r[h] <= PREF_POOL_RST;
        io_next_r[h]   <= {16'h0000, IO_POOL_RST};
      end
      bus_r   <= BUS_FIRST;
      level_r <= '0;
    end else if (ctl.commit) begin
      unique case (op_r)
        OP_BAR, OP_ROM: begin
          if (impl_r) begin
            unique case (sel_r)
              POOL_MEM:  mem_next_r[host_r]  <= pool_adv;
              POOL_PREF: pref_next_r[host_r] <= pool_adv;
              POOL_IO:   io_next_r[host_r]   <= pool_adv;
              default: ;
            endcase
          end
        end
        OP_ENTER: begin
          if (!lvl_full) begin
            mem_next_r[host_r]  <= t_r[0];
            pref_next_r[host_r] <= t_r[1];
            io_next_r[host_r]   <= t_r[2];
            level_r <= level_r + LVL_W'(1);
            bus_r   <= bus_r + 8'd1;
          end
        end
        OP_LEAVE: begin
          if (!lvl_empty) begin
            level_r <= lvl_m1;
            if (mem_en) begin
              mem_next_r[host_r] <= mem_rnd;
            end
            if (pref_en) begin
              pref_next_r[host_r] <= pref_rnd;
            end
            if (io_en) begin
              io_next_r[host_r] <= io_rnd;
            end
          end
        end
        OP_START: begin
          mem_next_r[host_r]  <= mem_start_r;
          pref_next_r[host_r] <= pref_start_r;
          io_next_r[host_r]   <= {16'h0000, io_start_r};
          bus_r   <= BUS_FIRST;
          level_r <= '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    bar_word_nxt     = '0;
    region_size_nxt  = '0;
    wide_bar_nxt     = 1'b0;
    command_bits_nxt = '0;
    bus_number_nxt   = '0;
    mem_base_nxt     = '0;
    mem_limit_nxt    = '0;
    pref_base_nxt    = '0;
    pref_limit_nxt   = '0;
    io_base_nxt      = '0;
    io_limit_nxt     = '0;
    nest_err_nxt     = 1'b0;
    unique case (op_r)
      OP_BAR, OP_ROM: begin
        if (impl_r) begin
          bar_word_nxt     = rom_r ? (base_r | 32'd1) : (flags_r | base_r);
          region_size_nxt  = size_r;
          wide_bar_nxt     = !rom_r && !io_r && (orig_r[2:1] == 2'b10);
          command_bits_nxt = (io_r ? CMD_IO : CMD_MEM) | CMD_MASTER;
        end
      end
      OP_ENTER: begin
        if (lvl_full) begin
          nest_err_nxt = 1'b1;
        end else begin
          bus_number_nxt = bus_r;
        end
      end
      OP_LEAVE: begin
        if (lvl_empty) begin
          nest_err_nxt = 1'b1;
        end else begin
          bus_number_nxt = bus_r - 8'd1;
          if (mem_en) begin
            mem_base_nxt     = {t_r[0][31:20], 4'h0};
            mem_limit_nxt    = {mem_m1[31:20], 4'h0};
            command_bits_nxt = command_bits_nxt | CMD_MEM;
          end else begin
            mem_base_nxt = MEM_WIN_OFF;
          end
          if (pref_en) begin
            pref_base_nxt    = {t_r[1][31:20], 4'h0};
            pref_limit_nxt   = {pref_m1[31:20], 4'h0};
            command_bits_nxt = command_bits_nxt | CMD_MEM;
          end else begin
            pref_base_nxt = MEM_WIN_OFF;
          end
          if (io_en) begin
            io_base_nxt      = {t_r[2][15:12], 4'h0};
            io_limit_nxt     = {io_m1[15:12], 4'h0};
            command_bits_nxt = command_bits_nxt | CMD_IO;
          end else begin
            io_base_nxt = IO_WIN_OFF;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op_r   <= in_opcode;
      host_r <= HOST_W'(in_host_select);
      orig_r <= in_original_word;
      rb_r   <= in_readback_word;
    end
    if (ctl.calc) begin
      base_r  <= (pool_cur + ~x) & x;
      size_r  <= ~x + 32'd1;
      flags_r <= flags;
      sel_r   <= sel;
      rom_r   <= is_rom;
      io_r    <= is_io;
      impl_r  <= (x != 32'd0);
      if (op_r == OP_LEAVE) begin
        t_r[0] <= stk_mem[rd_idx];
        t_r[1] <= stk_pref[rd_idx];
        t_r[2] <= stk_io[rd_idx];
      end else begin
        t_r[0] <= (mem_cur + MEM_GRAN_M1) & ~MEM_GRAN_M1;
        t_r[1] <= (pref_cur + MEM_GRAN_M1) & ~MEM_GRAN_M1;
        t_r[2] <= (io_cur + IO_GRAN_M1) & ~IO_GRAN_M1;
      end
    end
    if (ctl.commit) begin
      if ((op_r == OP_ENTER) && !lvl_full) begin
        stk_mem[wr_idx]  <= t_r[0];
        stk_pref[wr_idx] <= t_r[1];
        stk_io[wr_idx]   <= t_r[2];
      end
      bar_word_r     <= bar_word_nxt;
      region_size_r  <= region_size_nxt;
      wide_bar_r     <= wide_bar_nxt;
      command_bits_r <= command_bits_nxt;
      bus_number_r   <= bus_number_nxt;
      mem_base_r     <= mem_base_nxt;
      mem_limit_r    <= mem_limit_nxt;
      pref_base_r    <= pref_base_nxt;
      pref_limit_r   <= pref_limit_nxt;
      io_base_r      <= io_base_nxt;
      io_limit_r     <= io_limit_nxt;
      nest_err_r     <= nest_err_nxt;
    end
  end

  assign out_bar_word          = bar_word_r;
  assign out_region_size       = region_size_r;
  assign out_wide_bar          = wide_bar_r;
  assign out_command_bits      = command_bits_r;
  assign out_bus_number        = bus_number_r;
  assign out_mem_window_base   = mem_base_r;
  assign out_mem_window_limit  = mem_limit_r;
  assign out_pref_window_base  = pref_base_r;
  assign out_pref_window_limit = pref_limit_r;
  assign out_io_window_base    = io_base_r;
  assign out_io_window_limit   = io_limit_r;
  assign out_nesting_error     = nest_err_r;

endmodule

[rtl/prwa_ctrl.sv]
`timescale 1ns / 1ps

module prwa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output prwa_pkg::ctl_t ctl
);
  import prwa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_COMMIT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   commit_ok;

  assign commit_ok = (state_r == S_COMMIT) && (!out_valid_r || !out_stall);

  assign ctl.capture = (state_r == S_IDLE) && in_valid;
  assign ctl.calc    = (state_r == S_CALC);
  assign ctl.commit  = commit_ok;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_CALC;
          end
        end
        S_CALC: state_r <= S_COMMIT;
        S_COMMIT: begin
          if (commit_ok) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (commit_ok) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

[rtl/prwa_checker.sv]
`timescale 1ns / 1ps
`include "pci_resource_window_allocator_top_assert.svh"

module prwa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_bar_word,
  input logic [2:0]  out_command_bits,
  input logic [7:0]  out_bus_number,
  input logic        out_nesting_error
);

  logic in_acc;

  assign in_acc = in_valid && !in_stall;

  // The block holds off new beats while an accepted item is being worked on.
  `PRWA_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_acc, in_stall ##1 in_stall)

  // An item accepted while no result beat waits shows its result after the calculate and commit steps.
  `PRWA_ASSERT_IMP(a_result_follows, clk, rst_n, in_acc && !out_valid, ##3 out_valid)

  // A refused bridge step reports no bus number and no forwarding bits.
  `PRWA_ASSERT_IMP(a_error_clean, clk, rst_n, out_valid && out_nesting_error,
                   out_bus_number == 8'd0 && out_command_bits == 3'd0)

  // A stalled result beat keeps its payload.
  `PRWA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                   out_valid && $stable(out_bar_word))

endmodule

bind pci_resource_window_allocator_top prwa_checker u_prwa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_bar_word      (out_bar_word),
  .out_command_bits  (out_command_bits),
  .out_bus_number    (out_bus_number),
  .out_nesting_error (out_nesting_error)
);
